/* rtl/core/mts_pkg.sv */
// Package for the melody tone sequencer: constants, item types and helper functions.
package mts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SONG_STRIDE = 217;
  localparam int REST_BEATS  = 10;
  localparam int PTR_W       = $clog2(TABLE_DEPTH);

  localparam logic [7:0] MARK_REST = 8'hFF;
  localparam logic [7:0] MARK_END  = 8'h00;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TONE  = 2'd2,
    REQ_BEAT  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_TONE = 3'b010,
    PH_REST = 3'b100
  } phase_t;

  typedef struct packed {
    req_t       req_type;
    logic [9:0] load_addr;
    logic [7:0] load_data;
    logic [1:0] song_number;
    logic       play_mode;
  } in_item_t;

  typedef struct packed {
    logic tone_out;
    logic playing;
    logic song_done;
  } out_item_t;

  // Item in the work stage, as seen by the sequencer core
  typedef struct packed {
    logic             valid;
    logic             adv;
    in_item_t         item;
    logic [PTR_W-1:0] fetch_addr;
  } stage_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (32'(p) == TABLE_DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] song_base(input logic [1:0] s);
    logic [PTR_W-1:0] r;
    case (s)
      2'd0:    r = '0;
      2'd1:    r = PTR_W'((1 * SONG_STRIDE) % TABLE_DEPTH);
      2'd2:    r = PTR_W'((2 * SONG_STRIDE) % TABLE_DEPTH);
      2'd3:    r = PTR_W'((3 * SONG_STRIDE) % TABLE_DEPTH);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/mts_in_if.sv */
// Input channel interface of the melody tone sequencer.
interface mts_in_if
  import mts_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mts_out_if.sv */
// Result channel interface of the melody tone sequencer.
interface mts_out_if
  import mts_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mts_table.sv */
// Song table memory: one write port, two registered reads at consecutive addresses.
module mts_table
  import mts_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [PTR_W-1:0] rd_addr,
  output logic [7:0]       rd0_r,
  output logic [7:0]       rd1_r
);

  logic [7:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // tone byte and its duration byte
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0_r <= mem[rd_addr];
      rd1_r <= mem[ptr_inc(rd_addr)];
    end
  end

endmodule

/* rtl/core/mts_core.sv */
// Sequencer core: play state and the per-item update of tone, beat and entry logic.
module mts_core
  import mts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  stage_t           stg,
  input  logic [7:0]       rd0,
  input  logic [7:0]       rd1,
  output out_item_t        res,
  output logic [PTR_W-1:0] ptr_fwd
);

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       half_r, half_nxt;
  logic [8:0]       cnt_r, cnt_nxt;
  logic [7:0]       beat_r, beat_nxt;
  logic [7:0]       target_r, target_nxt;
  logic             level_r, level_nxt;

  phase_t     phase_c;
  logic       level_c;
  logic       do_entry;
  logic       done;
  logic [8:0] cnt_inc;
  logic [7:0] beat_inc;

  always_comb begin
    case (phase_r)
      PH_TONE: begin
        phase_c = PH_TONE;
        level_c = level_r;
      end
      PH_REST: begin
        phase_c = PH_REST;
        level_c = level_r;
      end
      default: begin
        phase_c = PH_IDLE;
        level_c = 1'b0;
      end
    endcase
  end

  assign cnt_inc  = cnt_r + 9'd1;
  assign beat_inc = beat_r + 8'd1;

  always_comb begin
    ptr_nxt    = ptr_r;
    phase_nxt  = phase_c;
    half_nxt   = half_r;
    cnt_nxt    = cnt_r;
    beat_nxt   = beat_r;
    target_nxt = target_r;
    level_nxt  = level_c;
    do_entry   = 1'b0;
    done       = 1'b0;

    case (stg.item.req_type)
      REQ_LOAD: begin
      end
      REQ_START: begin
        do_entry = 1'b1;
      end
      REQ_TONE: begin
        if (phase_c == PH_TONE) begin
          cnt_nxt = (cnt_inc > {half_r, 1'b0}) ? 9'd0 : cnt_inc;
          level_nxt = (cnt_nxt < {1'b0, half_r});
        end
      end
      REQ_BEAT: begin
        if (phase_c != PH_IDLE) begin
          beat_nxt = beat_inc;
          if (beat_inc >= target_r) begin
            beat_nxt = 8'd0;
            if (phase_c == PH_TONE && !stg.item.play_mode) begin
              phase_nxt = PH_IDLE;
              level_nxt = 1'b0;
              done      = 1'b1;
            end else begin
              do_entry = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // entry bytes were read at fetch_addr when the item was accepted
    if (do_entry) begin
      beat_nxt = 8'd0;
      if (rd0 == MARK_END) begin
        ptr_nxt   = ptr_inc(stg.fetch_addr);
        phase_nxt = PH_IDLE;
        level_nxt = 1'b0;
        done      = 1'b1;
      end else if (rd0 == MARK_REST) begin
        ptr_nxt    = ptr_inc(stg.fetch_addr);
        phase_nxt  = PH_REST;
        target_nxt = 8'(REST_BEATS);
        level_nxt  = 1'b0;
      end else begin
        ptr_nxt    = ptr_inc(ptr_inc(stg.fetch_addr));
        phase_nxt  = PH_TONE;
        half_nxt   = rd0;
        cnt_nxt    = 9'd0;
        target_nxt = (rd1 == 8'd0) ? 8'd1 : rd1;
        level_nxt  = 1'b1;
      end
    end
  end

  assign res.tone_out  = level_nxt;
  assign res.playing   = (phase_nxt != PH_IDLE);
  assign res.song_done = done;

  // pointer as the next accepted item will see it
  assign ptr_fwd = stg.valid ? ptr_nxt : ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      phase_r  <= PH_IDLE;
      half_r   <= '0;
      cnt_r    <= '0;
      beat_r   <= '0;
      target_r <= '0;
      level_r  <= 1'b0;
    end else if (stg.adv) begin
      ptr_r    <= ptr_nxt;
      phase_r  <= phase_nxt;
      half_r   <= half_nxt;
      cnt_r    <= cnt_nxt;
      beat_r   <= beat_nxt;
      target_r <= target_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

/* rtl/core/melody_tone_sequencer.sv */
// Melody tone sequencer: takes one item per clock cycle and returns one result per
// item, through the input register and then the result register. The song
// table is read on acceptance at two consecutive addresses, so a whole tone entry is
// available to the following cycle's update; a full result register that is not taken
// holds the input register and ready drops. No clearing pass after reset: table
// entries are valid only once loaded.
module melody_tone_sequencer
  import mts_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);

  logic             accept;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] ptr_fwd;
  logic             wr_en;
  logic [7:0]       rd0, rd1;

  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic [PTR_W-1:0] s1_fetch_r;
  logic             s1_adv;
  stage_t           stg;

  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        res;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  assign rd_addr = (in_ch.data.req_type == REQ_START) ? song_base(in_ch.data.song_number)
                                                      : ptr_fwd;
  assign wr_en   = accept && (in_ch.data.req_type == REQ_LOAD) &&
                   (32'(in_ch.data.load_addr) < TABLE_DEPTH);

  mts_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (PTR_W'(in_ch.data.load_addr)),
    .wr_data (in_ch.data.load_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd0_r   (rd0),
    .rd1_r   (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= in_ch.data;
      s1_fetch_r <= rd_addr;
    end
  end

  assign stg.valid      = s1_valid_r;
  assign stg.adv        = s1_adv;
  assign stg.item       = s1_item_r;
  assign stg.fetch_addr = s1_fetch_r;

  mts_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stg     (stg),
    .rd0     (rd0),
    .rd1     (rd1),
    .res     (res),
    .ptr_fwd (ptr_fwd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_done_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.song_done |-> !out_data_r.playing)
    else $error("song_done with playing set");

  a_tone_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tone_out |-> out_data_r.playing)
    else $error("tone high while not playing");

  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item lost before result register");

endmodule

/* bench/tb_melody_tone_sequencer.sv */
`timescale 1ns / 100ps
// Testbench for melody_tone_sequencer: songs and noise in, each result checked against a predictor.
module tb_melody_tone_sequencer;
  import mts_pkg::*;

  typedef struct {
    logic [PTR_W-1:0] ptr;
    phase_t           ph;
    logic [7:0]       half;
    logic [8:0]       tcnt;
    logic [7:0]       bcnt;
    logic [7:0]       btarget;
    logic             level;
  } player_t;

  typedef struct {
    in_item_t  item;
    out_item_t res;
  } queued_item_t;

  logic clk;
  logic rst_n;

  mts_in_if  in_ch();
  mts_out_if out_ch();

  melody_tone_sequencer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]       song_mem [TABLE_DEPTH];
  bit               mem_written [TABLE_DEPTH];
  player_t          player;
  bit               missing_read;
  logic [PTR_W-1:0] missing_addr;

  queued_item_t item_backlog[$];
  out_item_t    levels_due[$];
  out_item_t    cur_res;
  out_item_t    want;
  int           n_total;
  int           n_accepted;
  int           errors;
  int           gap;
  int           hold;
  bit           pressure_done;
  bit           gen_done;
  bit           quiet;

  function automatic logic [7:0] read_song_byte();
    logic [7:0] b;
    if (!mem_written[player.ptr] && !missing_read) begin
      missing_read = 1'b1;
      missing_addr = player.ptr;
    end
    b = song_mem[player.ptr];
    player.ptr = PTR_W'((int'(player.ptr) + 1) % TABLE_DEPTH);
    return b;
  endfunction

  // Starts the entry at the read pointer; returns 1 when it is the end marker.
  function automatic bit open_entry();
    logic [7:0] t;
    t = read_song_byte();
    player.bcnt = '0;
    if (t == MARK_END) begin
      player.ph = PH_IDLE;
      player.level = 1'b0;
      return 1'b1;
    end
    if (t == MARK_REST) begin
      player.ph = PH_REST;
      player.btarget = 8'(REST_BEATS);
      player.level = 1'b0;
      return 1'b0;
    end
    player.half = t;
    player.tcnt = '0;
    player.btarget = read_song_byte();
    if (player.btarget == 8'd0) begin
      player.btarget = 8'd1;
    end
    player.ph = PH_TONE;
    player.level = 1'b1;
    return 1'b0;
  endfunction

  function automatic out_item_t advance_player(in_item_t it);
    out_item_t r;
    bit        done;
    done = 1'b0;
    if (player.ph != PH_TONE && player.ph != PH_REST) begin
      player.ph = PH_IDLE;
      player.level = 1'b0;
    end
    case (it.req_type)
      REQ_LOAD: begin
        if (int'(it.load_addr) < TABLE_DEPTH) begin
          song_mem[it.load_addr] = it.load_data;
          mem_written[it.load_addr] = 1'b1;
        end
      end
      REQ_START: begin
        player.ptr = PTR_W'((int'(it.song_number) * SONG_STRIDE) % TABLE_DEPTH);
        done = open_entry();
      end
      REQ_TONE: begin
        if (player.ph == PH_TONE) begin
          player.tcnt = player.tcnt + 9'd1;
          if (player.tcnt > {player.half, 1'b0}) begin
            player.tcnt = '0;
          end
          player.level = (player.tcnt < {1'b0, player.half});
        end
      end
      default: begin
        if (player.ph != PH_IDLE) begin
          player.bcnt = player.bcnt + 8'd1;
          if (player.bcnt >= player.btarget) begin
            player.bcnt = '0;
            if (player.ph == PH_TONE && !it.play_mode) begin
              player.ph = PH_IDLE;
              player.level = 1'b0;
              done = 1'b1;
            end else begin
              done = open_entry();
            end
          end
        end
      end
    endcase
    r.tone_out  = player.level;
    r.playing   = (player.ph != PH_IDLE);
    r.song_done = done;
    return r;
  endfunction

  function automatic in_item_t mk_item(req_t r);
    in_item_t it;
    it.req_type    = r;
    it.load_addr   = 10'($urandom_range(0, 1023));
    it.load_data   = 8'($urandom_range(0, 255));
    it.song_number = 2'($urandom_range(0, 3));
    it.play_mode   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Queues an item; if it would read a table byte never loaded, loads that byte first.
  task automatic add_item(in_item_t it);
    player_t      saved;
    queued_item_t q;
    in_item_t     fix;
    forever begin
      saved = player;
      missing_read = 1'b0;
      q.res = advance_player(it);
      if (!missing_read) break;
      player = saved;
      fix = mk_item(REQ_LOAD);
      fix.load_addr = missing_addr;
      if ($urandom_range(0, 1) == 0) fix.load_data = MARK_END;
      q.item = fix;
      q.res = advance_player(fix);
      item_backlog.push_back(q);
      n_total++;
    end
    q.item = it;
    item_backlog.push_back(q);
    n_total++;
  endtask

  task automatic put_load(int a, logic [7:0] d);
    in_item_t it;
    it = mk_item(REQ_LOAD);
    it.load_addr = PTR_W'(a % TABLE_DEPTH);
    it.load_data = d;
    add_item(it);
  endtask

  task automatic put_start(int s);
    in_item_t it;
    it = mk_item(REQ_START);
    it.song_number = 2'(s);
    add_item(it);
  endtask

  task automatic put_beat(logic m);
    in_item_t it;
    it = mk_item(REQ_BEAT);
    it.play_mode = m;
    add_item(it);
  endtask

  // driver
  always @(posedge clk) begin
    queued_item_t e;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        levels_due.push_back(cur_res);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap > 0) begin
          gap--;
          in_ch.valid <= 1'b0;
        end else if (item_backlog.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(0, 3);
          in_ch.valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          e = item_backlog.pop_front();
          cur_res = e.res;
          in_ch.data <= e.item;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (levels_due.size() == 0) begin
          $error("unexpected result: tone_out %0d playing %0d song_done %0d",
                 out_ch.data.tone_out, out_ch.data.playing, out_ch.data.song_done);
          errors++;
        end else begin
          want = levels_due.pop_front();
          if (out_ch.data.tone_out !== want.tone_out) begin
            $error("tone_out: expected %0d, got %0d", want.tone_out, out_ch.data.tone_out);
            errors++;
          end
          if (out_ch.data.playing !== want.playing) begin
            $error("playing: expected %0d, got %0d", want.playing, out_ch.data.playing);
            errors++;
          end
          if (out_ch.data.song_done !== want.song_done) begin
            $error("song_done: expected %0d, got %0d", want.song_done, out_ch.data.song_done);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!pressure_done && n_accepted >= 300) begin
        pressure_done = 1'b1;
        hold = 40;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    quiet <= gen_done && item_backlog.size() < 150;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int s;
    int a;
    int n;
    int budget;
    int r;
    int base3;
    bit wrap_done;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    quiet = 1'b0;
    player = '{ptr: '0, ph: PH_IDLE, half: '0, tcnt: '0, bcnt: '0, btarget: '0, level: 1'b0};
    wrap_done = 1'b0;

    // directed: idle ticks, extreme tones, zero duration, rest, abort
    base3 = (3 * SONG_STRIDE) % TABLE_DEPTH;
    add_item(mk_item(REQ_TONE));
    put_beat(1'b1);
    put_load(TABLE_DEPTH - 1, 8'hFF);
    put_load(base3, 8'd1);
    put_load(base3 + 1, 8'd0);
    put_load(base3 + 2, MARK_REST);
    put_load(base3 + 3, 8'd254);
    put_load(base3 + 4, 8'd1);
    put_load(base3 + 5, MARK_END);
    put_start(3);
    add_item(mk_item(REQ_TONE));
    add_item(mk_item(REQ_TONE));
    put_beat(1'b1);
    for (int i = 0; i < REST_BEATS; i++) put_beat(1'b1);
    add_item(mk_item(REQ_TONE));
    put_beat(1'b0);

    while (n_total < 1325) begin
      if (!wrap_done && n_total > 300) begin
        // one long song running past the top of the table
        wrap_done = 1'b1;
        a = base3;
        for (int k = 0; a != 5 && k < 400; k++) begin
          put_load(a, 8'($urandom_range(1, 254)));
          put_load(a + 1, 8'($urandom_range(0, 1)));
          a = (a + 2) % TABLE_DEPTH;
        end
        put_load(a, MARK_END);
        put_start(3);
        while (player.ph != PH_IDLE) begin
          if ($urandom_range(0, 3) == 0) add_item(mk_item(REQ_TONE));
          else put_beat(1'b1);
        end
      end else begin
        s = $urandom_range(0, 3);
        a = (s * SONG_STRIDE) % TABLE_DEPTH;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) < 2) begin
            put_load(a, MARK_REST);
            a = (a + 1) % TABLE_DEPTH;
          end else begin
            if ($urandom_range(0, 5) == 0) put_load(a, 8'($urandom_range(200, 254)));
            else put_load(a, 8'($urandom_range(1, 8)));
            if ($urandom_range(0, 11) == 0) put_load(a + 1, 8'($urandom_range(0, 255)));
            else put_load(a + 1, 8'($urandom_range(0, 3)));
            a = (a + 2) % TABLE_DEPTH;
          end
        end
        if ($urandom_range(0, 9) != 0) put_load(a, MARK_END);
        put_start(s);
        budget = $urandom_range(20, 80);
        for (int j = 0; j < budget; j++) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            add_item(mk_item(REQ_TONE));
          end else if (r < 88) begin
            put_beat($urandom_range(0, 9) != 0);
          end else if (r < 94) begin
            add_item(mk_item(REQ_LOAD));
          end else begin
            put_start($urandom_range(0, 3));
          end
          if (player.ph == PH_IDLE && $urandom_range(0, 2) == 0) break;
        end
      end
    end
    gen_done = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (item_backlog.size() > 0 || n_accepted < n_total) @(posedge clk);
    while (levels_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && levels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
